@@ hw/rtl/bsrf_pkg.sv @@
package bsrf_pkg;

    // Fixed-point word inside the datapath: wide enough for x^3 at |x| = 1.6
    localparam int FX_W     = 32;
    localparam int IN_W     = 30;
    localparam int TOL_W    = 29;
    localparam int STEP_W   = 7;
    localparam int STAT_W   = 2;
    localparam int PC_W     = 5;
    // f is applied this many times for one evaluation of g
    localparam int F_COUNT  = 4;
    localparam int FCNT_W   = 2;

    typedef logic signed [FX_W-1:0] fx_t;
    typedef logic [PC_W-1:0]        upc_t;

    typedef enum logic [STAT_W-1:0] {
        ST_CONVERGED = 2'd0,
        ST_NO_SIGN   = 2'd1,
        ST_STEP_LIM  = 2'd2
    } status_t;

    // Datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT,
        OP_SETX_A,
        OP_SAVE_GA_SETX_B,
        OP_SETX_MID,
        OP_UPDATE,
        OP_SET_NB,
        OP_SET_LIM,
        OP_EMIT,
        OP_MUL_XX,
        OP_WB_X2,
        OP_MUL_X2X,
        OP_WB_X3,
        OP_MUL_KX,
        OP_WB_F
    } op_t;

    // Jump conditions: taken goes to target (return: saved step), else next step
    typedef enum logic [3:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NO_INPUT,
        JC_CALL,
        JC_RETURN,
        JC_F_LOOP,
        JC_NO_BRACKET,
        JC_CONVERGED,
        JC_STEP_LIMIT,
        JC_OUT_BUSY
    } jc_t;

    typedef struct packed {
        op_t  op;
        jc_t  jc;
        upc_t target;
    } uword_t;

    // Status flags that the sequencer branches on
    typedef struct packed {
        logic in_valid;
        logic no_bracket;
        logic converged;
        logic step_limit;
        logic out_busy;
    } flags_t;

    localparam upc_t A_WAIT = 5'd0;
    localparam upc_t A_TEST = 5'd5;
    localparam upc_t A_NB   = 5'd9;
    localparam upc_t A_LIM  = 5'd10;
    localparam upc_t A_OUT  = 5'd11;
    localparam upc_t A_G    = 5'd13;

    // The stop test after a halving uses g of the previous midpoint and the
    // new width; the next midpoint and its g are formed only once the loop goes on
    function automatic uword_t ucode_rom(input upc_t addr);
        uword_t w;
        begin
            w = '{op: OP_NOP, jc: JC_ALWAYS, target: A_WAIT};
            unique case (addr)
                5'd0:  w = '{op: OP_WAIT,           jc: JC_NO_INPUT,   target: A_WAIT};
                5'd1:  w = '{op: OP_SETX_A,         jc: JC_CALL,       target: A_G};
                5'd2:  w = '{op: OP_SAVE_GA_SETX_B, jc: JC_CALL,       target: A_G};
                5'd3:  w = '{op: OP_NOP,            jc: JC_NO_BRACKET, target: A_NB};
                5'd4:  w = '{op: OP_SETX_MID,       jc: JC_CALL,       target: A_G};
                5'd5:  w = '{op: OP_NOP,            jc: JC_CONVERGED,  target: A_OUT};
                5'd6:  w = '{op: OP_NOP,            jc: JC_STEP_LIMIT, target: A_LIM};
                5'd7:  w = '{op: OP_SETX_MID,       jc: JC_CALL,       target: A_G};
                5'd8:  w = '{op: OP_UPDATE,         jc: JC_ALWAYS,     target: A_TEST};
                5'd9:  w = '{op: OP_SET_NB,         jc: JC_ALWAYS,     target: A_OUT};
                5'd10: w = '{op: OP_SET_LIM,        jc: JC_NEVER,      target: A_WAIT};
                5'd11: w = '{op: OP_EMIT,           jc: JC_OUT_BUSY,   target: A_OUT};
                5'd12: w = '{op: OP_NOP,            jc: JC_ALWAYS,     target: A_WAIT};
                5'd13: w = '{op: OP_MUL_XX,         jc: JC_NEVER,      target: A_WAIT};
                5'd14: w = '{op: OP_WB_X2,          jc: JC_NEVER,      target: A_WAIT};
                5'd15: w = '{op: OP_MUL_X2X,        jc: JC_NEVER,      target: A_WAIT};
                5'd16: w = '{op: OP_WB_X3,          jc: JC_NEVER,      target: A_WAIT};
                5'd17: w = '{op: OP_MUL_KX,         jc: JC_NEVER,      target: A_WAIT};
                5'd18: w = '{op: OP_WB_F,           jc: JC_F_LOOP,     target: A_G};
                5'd19: w = '{op: OP_NOP,            jc: JC_RETURN,     target: A_WAIT};
                default: w = '{op: OP_NOP, jc: JC_ALWAYS, target: A_WAIT};
            endcase
            return w;
        end
    endfunction

endpackage

@@ hw/rtl/bsrf_seq.sv @@
module bsrf_seq
    import bsrf_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  flags_t flags,
    output op_t    op
);

    upc_t                pc_reg,   pc_next;
    upc_t                ret_reg,  ret_next;
    logic [FCNT_W-1:0]   fcnt_reg, fcnt_next;
    uword_t              uw;
    logic                taken;
    upc_t                pc_inc;

    always_comb begin
        uw     = ucode_rom(pc_reg);
        op     = uw.op;
        pc_inc = pc_reg + upc_t'(1);
        taken  = 1'b0;
        unique case (uw.jc)
            JC_NEVER:      taken = 1'b0;
            JC_ALWAYS:     taken = 1'b1;
            JC_NO_INPUT:   taken = !flags.in_valid;
            JC_CALL:       taken = 1'b1;
            JC_RETURN:     taken = 1'b1;
            JC_F_LOOP:     taken = (fcnt_reg != FCNT_W'(F_COUNT - 1));
            JC_NO_BRACKET: taken = flags.no_bracket;
            JC_CONVERGED:  taken = flags.converged;
            JC_STEP_LIMIT: taken = flags.step_limit;
            JC_OUT_BUSY:   taken = flags.out_busy;
            default:       taken = 1'b0;
        endcase

        ret_next  = ret_reg;
        fcnt_next = fcnt_reg;
        if (uw.jc == JC_CALL) begin
            ret_next  = pc_inc;
            fcnt_next = '0;
        end
        if (uw.jc == JC_F_LOOP) begin
            fcnt_next = fcnt_reg + FCNT_W'(1);
        end

        if (uw.jc == JC_RETURN) begin
            pc_next = ret_reg;
        end else if (taken) begin
            pc_next = uw.target;
        end else begin
            pc_next = pc_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= A_WAIT;
            ret_reg  <= A_WAIT;
            fcnt_reg <= '0;
        end else begin
            pc_reg   <= pc_next;
            ret_reg  <= ret_next;
            fcnt_reg <= fcnt_next;
        end
    end

endmodule

@@ hw/rtl/bsrf_dp.sv @@
module bsrf_dp
    import bsrf_pkg::*;
#(
    parameter int MAX_STEPS = 64,
    parameter int FRAC_BITS = 28
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  op_t                     op,
    input  logic                    in_accept,
    input  logic signed [IN_W-1:0]  lower_bound,
    input  logic signed [IN_W-1:0]  upper_bound,
    input  logic [TOL_W-1:0]        tolerance,
    output logic                    no_bracket,
    output logic                    converged,
    output logic                    step_limit,
    output logic signed [IN_W-1:0]  root,
    output status_t                 status,
    output logic [STEP_W-1:0]       steps_taken
);

    localparam longint ONE_FX = 64'sd1 <<< FRAC_BITS;
    localparam fx_t    K22    = fx_t'((22 * ONE_FX + 5) / 10);
    localparam fx_t    LIMIT  = fx_t'((16 * ONE_FX + 5) / 10);
    localparam logic signed [2*FX_W-1:0] RND = (2*FX_W)'(ONE_FX - 1);

    fx_t a_reg,  a_next;
    fx_t b_reg,  b_next;
    fx_t c_reg,  c_next;
    fx_t x_reg,  x_next;
    fx_t x2_reg, x2_next;
    fx_t x3_reg, x3_next;
    fx_t ga_reg, ga_next;
    logic signed [2*FX_W-1:0] prod_reg, prod_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    status_t status_reg, status_next;

    fx_t lo_ext, hi_ext, lo_clamp, hi_clamp;
    fx_t mul_a, mid, diff;
    fx_t trunc;
    logic signed [2*FX_W-1:0] prod_biased;
    logic [FX_W-1:0] abs_x, abs_w;
    logic opposite;

    always_comb begin
        lo_ext = {{(FX_W-IN_W){lower_bound[IN_W-1]}}, lower_bound};
        hi_ext = {{(FX_W-IN_W){upper_bound[IN_W-1]}}, upper_bound};
        priority if (lo_ext > LIMIT)  lo_clamp = LIMIT;
        else if (lo_ext < -LIMIT)     lo_clamp = -LIMIT;
        else                          lo_clamp = lo_ext;
        priority if (hi_ext > LIMIT)  hi_clamp = LIMIT;
        else if (hi_ext < -LIMIT)     hi_clamp = -LIMIT;
        else                          hi_clamp = hi_ext;

        // Truncate toward zero: bias negative products before the shift
        prod_biased = prod_reg[2*FX_W-1] ? (prod_reg + RND) : prod_reg;
        trunc       = fx_t'(prod_biased >>> FRAC_BITS);

        mid   = (a_reg + b_reg) >>> 1;
        diff  = b_reg - a_reg;
        abs_x = x_reg[FX_W-1] ? FX_W'(-x_reg) : FX_W'(x_reg);
        abs_w = diff[FX_W-1]  ? FX_W'(-diff)  : FX_W'(diff);

        // x holds g(b) after the second evaluation, g(mid) after later ones
        no_bracket = (ga_reg != '0) && (x_reg != '0) && (ga_reg[FX_W-1] == x_reg[FX_W-1]);
        converged  = !((abs_x > FX_W'(tolerance)) && (abs_w > FX_W'(tolerance)));
        step_limit = (steps_reg >= STEP_W'(MAX_STEPS));
        opposite   = ((ga_reg < 0) && (x_reg > 0)) || ((ga_reg > 0) && (x_reg < 0));

        unique case (op)
            OP_MUL_X2X: mul_a = x2_reg;
            OP_MUL_KX:  mul_a = K22;
            default:    mul_a = x_reg;
        endcase
        prod_next = mul_a * x_reg;

        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        x_next      = x_reg;
        x2_next     = x2_reg;
        x3_next     = x3_reg;
        ga_next     = ga_reg;
        steps_next  = steps_reg;
        status_next = status_reg;

        unique case (op)
            OP_WAIT: begin
                if (in_accept) begin
                    a_next      = lo_clamp;
                    b_next      = hi_clamp;
                    steps_next  = '0;
                    status_next = ST_CONVERGED;
                end
            end
            OP_SETX_A:  x_next = a_reg;
            OP_SAVE_GA_SETX_B: begin
                ga_next = x_reg;
                x_next  = b_reg;
            end
            OP_SETX_MID: begin
                c_next = mid;
                x_next = mid;
            end
            OP_UPDATE: begin
                if (opposite) begin
                    b_next = c_reg;
                end else begin
                    a_next  = c_reg;
                    ga_next = x_reg;
                end
                steps_next = steps_reg + STEP_W'(1);
            end
            OP_SET_NB: begin
                c_next      = '0;
                status_next = ST_NO_SIGN;
            end
            OP_SET_LIM: status_next = ST_STEP_LIM;
            OP_WB_X2:   x2_next = trunc;
            OP_WB_X3:   x3_next = trunc;
            OP_WB_F:    x_next  = x3_reg - trunc;
            default: begin
            end
        endcase

        root        = c_reg[IN_W-1:0];
        status      = status_reg;
        steps_taken = steps_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg  <= '0;
            status_reg <= ST_CONVERGED;
        end else begin
            steps_reg  <= steps_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        x_reg    <= x_next;
        x2_reg   <= x2_next;
        x3_reg   <= x3_next;
        ga_reg   <= ga_next;
        prod_reg <= prod_next;
    end

endmodule

@@ hw/rtl/bisection_root_finder.sv @@
// Channel  Dir  Ports               Word layout (low bit first)
// s_       in   tvalid/tready/tdata lower_bound[29:0], upper_bound[59:30], unused
// m_       out  tvalid/tready/tdata root[29:0], steps_taken[36:30], zeros
//                     tuser         status[1:0]
// cfg_     in   wr_en/wr_data       tolerance[28:0], written while wr_en is high
//
// A word ends on convergence, at the step limit of MAX_STEPS halvings or with no bracket;
// its emit step stalls while the output register still holds an untaken word. Each g
// evaluation is four passes of f through the one shared 32x32 multiplier, under the
// microcode sequencer.
// Reset (aresetn low, synchronous) returns the sequencer to its wait step,
// empties the output register and sets tolerance to 268435.
// A finished word waits in the output register; the next input is taken
// meanwhile, and only its own result step stalls while m_tready is low.
module bisection_root_finder
    import bsrf_pkg::*;
#(
    parameter int MAX_STEPS = 64,
    parameter int FRAC_BITS = 28
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [63:0]        s_tdata,   // lower_bound[29:0], upper_bound[59:30]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [39:0]        m_tdata,   // root[29:0], steps_taken[36:30]
    output logic [STAT_W-1:0]  m_tuser,   // status[1:0]
    input  logic               cfg_wr_en,
    input  logic [TOL_W-1:0]   cfg_wr_data
);

    op_t                    op;
    flags_t                 flags;
    logic                   in_accept;
    logic                   out_busy;
    logic                   no_bracket, converged, step_limit;
    logic signed [IN_W-1:0] root;
    status_t                status;
    logic [STEP_W-1:0]      steps_taken;

    logic [TOL_W-1:0]  tol_reg, tol_next;
    logic              m_valid_reg, m_valid_next;
    logic [39:0]       m_data_reg, m_data_next;
    logic [STAT_W-1:0] m_user_reg, m_user_next;

    // Input is taken only at the wait step of the microprogram
    assign s_tready  = (op == OP_WAIT);
    assign in_accept = s_tvalid && s_tready;
    // Output register still holds a word the sink has not taken
    assign out_busy  = m_valid_reg && !m_tready;

    always_comb begin
        flags.in_valid   = s_tvalid;
        flags.no_bracket = no_bracket;
        flags.converged  = converged;
        flags.step_limit = step_limit;
        flags.out_busy   = out_busy;
    end

    bsrf_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .op      (op)
    );

    bsrf_dp #(
        .MAX_STEPS (MAX_STEPS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .op          (op),
        .in_accept   (in_accept),
        .lower_bound (s_tdata[IN_W-1:0]),
        .upper_bound (s_tdata[2*IN_W-1:IN_W]),
        .tolerance   (tol_reg),
        .no_bracket  (no_bracket),
        .converged   (converged),
        .step_limit  (step_limit),
        .root        (root),
        .status      (status),
        .steps_taken (steps_taken)
    );

    always_comb begin
        tol_next = cfg_wr_en ? cfg_wr_data : tol_reg;

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        // Drop the word once taken; load a new one at the emit step when free
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if ((op == OP_EMIT) && !out_busy) begin
            m_valid_next = 1'b1;
            m_data_next  = {3'b000, steps_taken, root};
            m_user_next  = status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg     <= TOL_W'(268435);
            m_valid_reg <= 1'b0;
        end else begin
            tol_reg     <= tol_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTH
    // A no-bracket result carries a zero root and no halvings
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ST_NO_SIGN)) |-> (m_tdata[36:0] == 37'd0))
        else $error("no-bracket word with nonzero root or step count");

    // The step limit status appears only after exactly MAX_STEPS halvings
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ST_STEP_LIM)) |-> (m_tdata[36:30] == STEP_W'(MAX_STEPS)))
        else $error("step-limit word with wrong step count");

    // A converged result never exceeds the step limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ST_CONVERGED)) |-> (m_tdata[36:30] <= STEP_W'(MAX_STEPS)))
        else $error("converged word beyond the step limit");

    // After an input is taken the sequencer leaves its wait step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still ready right after an accept");
`endif

endmodule
